// ===== hdl/per_owner_memory_accounting_assert.svh =====
// Assertion macros for the per-owner memory accounting block.
// Expects a clock named clk and a synchronous active-high reset named rst.
`ifndef PER_OWNER_MEMORY_ACCOUNTING_ASSERT_SVH
`define PER_OWNER_MEMORY_ACCOUNTING_ASSERT_SVH

// Same-cycle implication, off during reset.
`define POMA_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define POMA_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/poma_pkg.sv =====
// Shared types and constants for the per-owner memory accounting block.
// No dependencies.
package poma_pkg;

  localparam int SLOT_COUNT_DEFAULT = 1024;
  localparam int HANDLE_W = 32;
  localparam int BYTES_W = 32;
  localparam int BAL_W = 48;
  localparam int TOTAL_W = 48;
  localparam int BLOCKS_W = 32;
  localparam int OP_W = 2;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_QUOT   = 6'b000100,
    S_PROD   = 6'b001000,
    S_INDEX  = 6'b010000,
    S_UPDATE = 6'b100000
  } state_t;

endpackage

// ===== hdl/poma_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Read data updates only when a read is enabled. No dependencies.
module poma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/per_owner_memory_accounting.sv =====
// Top level of the per-owner memory accounting block.
// Depends on poma_pkg, poma_ram and per_owner_memory_accounting_assert.svh.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one event word: operation
//   (allocation, free, query), owner_handle and byte_count. Output channel
//   (out_valid / out_stall) returns one word per event: counted,
//   owner_balance, total_bytes and total_blocks after the event.
//   A new event is accepted only once the last one has left S_UPDATE: the
//   slot index (handle mod SLOT_COUNT) is formed by a reciprocal multiply, a
//   back multiply and a correcting subtract in S_QUOT, S_PROD and S_INDEX,
//   the last of which also reads the slot table memory; S_UPDATE then writes
//   the slot back and loads the result.
//   Only one event is in flight, so no forwarding is needed on the table.
//   The result sits in an output register; a new event is accepted while it
//   waits, and that event holds in its write-back step until the output
//   register frees up, so a stalled receiver backs up to in_stall.
//   After reset a clearing pass writes every slot to zero, one per cycle;
//   in_stall stays high during it. Counters wrap.
module per_owner_memory_accounting #(
  parameter int SLOT_COUNT = poma_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [poma_pkg::OP_W-1:0]          operation,
  input  logic [poma_pkg::HANDLE_W-1:0]      owner_handle,
  input  logic [poma_pkg::BYTES_W-1:0]       byte_count,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               counted,
  output logic signed [poma_pkg::BAL_W-1:0]  owner_balance,
  output logic [poma_pkg::TOTAL_W-1:0]       total_bytes,
  output logic [poma_pkg::BLOCKS_W-1:0]      total_blocks
);

  import poma_pkg::*;

  `include "per_owner_memory_accounting_assert.svh"

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int SHIFT = HANDLE_W + IDX_W;
  localparam int RECIP_W = HANDLE_W + 1;
  localparam int PROD_W = HANDLE_W + RECIP_W;
  localparam int QN_W = HANDLE_W + CNT_W;
  localparam int ENTRY_W = HANDLE_W + BAL_W;
  localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / SLOT_COUNT;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam logic [CNT_W-1:0] SLOTS = CNT_W'(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  state_t state, state_next;

  logic [OP_W-1:0]       op_r;
  logic [HANDLE_W-1:0]   handle_r;
  logic [BYTES_W-1:0]    bytes_r;
  logic [PROD_W-1:0]     prod_r;
  logic [HANDLE_W-1:0]   qn_r;
  logic [IDX_W-1:0]      idx_r;
  logic [IDX_W-1:0]      clr_addr;
  logic [TOTAL_W-1:0]    bytes_in_use;
  logic [BLOCKS_W-1:0]   live_blocks;

  logic                  accept;
  logic                  out_free;
  logic                  commit;
  logic [HANDLE_W-1:0]   quot;
  logic [QN_W-1:0]       qn_full;
  logic [HANDLE_W-1:0]   rem_raw;
  logic [HANDLE_W-1:0]   rem_fix;
  logic [IDX_W-1:0]      idx_comb;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic                  ram_re;
  logic [ENTRY_W-1:0]    ram_rdata;

  logic [HANDLE_W-1:0]   slot_owner;
  logic [BAL_W-1:0]      slot_bal;
  logic                  is_alloc;
  logic                  is_free;
  logic                  mutate;
  logic                  claim;
  logic [HANDLE_W-1:0]   owner_new;
  logic [BAL_W-1:0]      bal_base;
  logic [BAL_W-1:0]      bal_new;
  logic                  match;
  logic [TOTAL_W-1:0]    bytes_in_use_next;
  logic [BLOCKS_W-1:0]   live_blocks_next;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign commit   = (state == S_UPDATE) && out_free;

  // index = handle mod SLOT_COUNT by reciprocal multiply and one correction
  assign quot     = HANDLE_W'(prod_r >> SHIFT);
  assign qn_full  = QN_W'(quot) * QN_W'(SLOTS);
  assign rem_raw  = handle_r - qn_r;
  assign rem_fix  = (rem_raw >= HANDLE_W'(SLOT_COUNT)) ?
                    rem_raw - HANDLE_W'(SLOT_COUNT) : rem_raw;
  assign idx_comb = rem_fix[IDX_W-1:0];

  assign slot_owner = ram_rdata[ENTRY_W-1:BAL_W];
  assign slot_bal   = ram_rdata[BAL_W-1:0];
  assign is_alloc   = (op_r == OP_ALLOC);
  assign is_free    = (op_r == OP_FREE);
  assign mutate     = is_alloc || is_free;

  always_comb begin
    claim     = mutate && ((slot_owner == '0) || (slot_bal == '0) || slot_bal[BAL_W-1]);
    owner_new = claim ? handle_r : slot_owner;
    bal_base  = (claim && slot_bal[BAL_W-1]) ? '0 : slot_bal;
    match     = (owner_new == handle_r);
    bal_new   = bal_base;
    if (match && is_alloc) begin
      bal_new = bal_base + BAL_W'(bytes_r);
    end else if (match && is_free) begin
      bal_new = bal_base - BAL_W'(bytes_r);
    end
    bytes_in_use_next = bytes_in_use;
    live_blocks_next  = live_blocks;
    if (is_alloc) begin
      bytes_in_use_next = bytes_in_use + TOTAL_W'(bytes_r);
      live_blocks_next  = live_blocks + BLOCKS_W'(1);
    end else if (is_free) begin
      bytes_in_use_next = bytes_in_use - TOTAL_W'(bytes_r);
      live_blocks_next  = live_blocks - BLOCKS_W'(1);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = {owner_new, bal_new};
    ram_re    = (state == S_INDEX);
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (commit && mutate) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_QUOT;
        end
      end
      S_QUOT:  state_next = S_PROD;
      S_PROD:  state_next = S_INDEX;
      S_INDEX: state_next = S_UPDATE;
      S_UPDATE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      out_valid    <= 1'b0;
      bytes_in_use <= '0;
      live_blocks  <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      if (commit) begin
        out_valid    <= 1'b1;
        bytes_in_use <= bytes_in_use_next;
        live_blocks  <= live_blocks_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= operation;
      handle_r <= owner_handle;
      bytes_r  <= byte_count;
    end
    if (state == S_QUOT) begin
      prod_r <= PROD_W'(handle_r) * PROD_W'(RECIP);
    end
    if (state == S_PROD) begin
      qn_r <= qn_full[HANDLE_W-1:0];
    end
    if (state == S_INDEX) begin
      idx_r <= idx_comb;
    end
    if (commit) begin
      counted       <= match;
      owner_balance <= match ? bal_new : '0;
      total_bytes   <= bytes_in_use_next;
      total_blocks  <= live_blocks_next;
    end
  end

  poma_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_comb),
    .rdata (ram_rdata)
  );

  `POMA_ASSERT_NOW(a_uncounted_zero, out_valid && !counted, owner_balance == '0,
                   "uncounted result carries a nonzero balance")
  `POMA_ASSERT_NEXT(a_accept_starts, accept, state == S_QUOT,
                    "accepted word did not start index computation")
  `POMA_ASSERT_NEXT(a_update_holds, (state == S_UPDATE) && out_valid && out_stall,
                    (state == S_UPDATE) && out_valid,
                    "write-back left while output register was blocked")

endmodule

// ===== tb/sv/tb_per_owner_memory_accounting.sv =====
// Testbench for per_owner_memory_accounting: drives allocation, free, query and
// spare words, checks every result word against an in-bench accounting predictor.
// Depends on poma_pkg and the per_owner_memory_accounting RTL.
`timescale 1ns / 100ps

module tb_per_owner_memory_accounting;
  import poma_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct {
    bit counted;
    bit [BAL_W-1:0] balance;
    bit [TOTAL_W-1:0] bytes;
    bit [BLOCKS_W-1:0] blocks;
  } event_result_t;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] operation = OP_QUERY;
  logic [HANDLE_W-1:0] owner_handle = '0;
  logic [BYTES_W-1:0] byte_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic counted;
  logic signed [BAL_W-1:0] owner_balance;
  logic [TOTAL_W-1:0] total_bytes;
  logic [BLOCKS_W-1:0] total_blocks;

  bit [HANDLE_W-1:0] owner_of [SLOTS];
  bit [BAL_W-1:0] balance_of [SLOTS];
  bit [TOTAL_W-1:0] bytes_live;
  bit [BLOCKS_W-1:0] blocks_live;

  event_result_t pending_results[$];
  int fail_count = 0;
  int items_sent = 0;
  int owner_hits = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit sender_idles = 1'b1;
  stall_mode_t stall_mode = STALL_NONE;

  per_owner_memory_accounting dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .owner_handle(owner_handle),
    .byte_count(byte_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .counted(counted),
    .owner_balance(owner_balance),
    .total_bytes(total_bytes),
    .total_blocks(total_blocks)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk) begin
    case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall <= ($urandom_range(0, 99) < 40);
      end
      default: begin
        out_stall <= ((cycle_count % 9) < 4);
      end
    endcase
  end

  function automatic event_result_t account_event(logic [OP_W-1:0] op,
                                                  logic [HANDLE_W-1:0] handle,
                                                  logic [BYTES_W-1:0] nbytes);
    event_result_t r;
    int unsigned idx;
    idx = handle % SLOTS;
    r = '{default: '0};
    if (op == OP_ALLOC || op == OP_FREE) begin
      if (op == OP_ALLOC) begin
        bytes_live = bytes_live + nbytes;
        blocks_live = blocks_live + 1;
      end else begin
        bytes_live = bytes_live - nbytes;
        blocks_live = blocks_live - 1;
      end
      if (owner_of[idx] == '0 || balance_of[idx] == '0 || balance_of[idx][BAL_W-1]) begin
        owner_of[idx] = handle;
        if (balance_of[idx][BAL_W-1]) balance_of[idx] = '0;
      end
      if (owner_of[idx] == handle) begin
        if (op == OP_ALLOC) balance_of[idx] = balance_of[idx] + nbytes;
        else balance_of[idx] = balance_of[idx] - nbytes;
        r.counted = 1'b1;
        r.balance = balance_of[idx];
      end
    end else if (owner_of[idx] == handle) begin
      r.counted = 1'b1;
      r.balance = balance_of[idx];
    end
    r.bytes = bytes_live;
    r.blocks = blocks_live;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    event_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with no event pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (want.counted) owner_hits++;
        check_field("counted", want.counted, counted);
        check_field("owner_balance", $signed(want.balance), owner_balance);
        check_field("total_bytes", want.bytes, total_bytes);
        check_field("total_blocks", want.blocks, total_blocks);
      end
    end
  end

  task automatic send_word(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] handle,
                           input logic [BYTES_W-1:0] nbytes);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = sender_idles ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    operation <= op;
    owner_handle <= handle;
    byte_count <= nbytes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(account_event(op, handle, nbytes));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_empty_slots();
    send_word(OP_QUERY, 32'h0, 32'h0);
    send_word(OP_QUERY, 32'h5, 32'hFFFF_FFFF);
    send_word(OP_SPARE, 32'h0, 32'h1234);
    send_word(OP_SPARE, 32'hFFFF_FFFF, 32'h0);
  endtask

  task automatic test_counter_wrap();
    send_word(OP_FREE, 32'h0, 32'hFFFF_FFFF);
    send_word(OP_ALLOC, 32'h400, 32'h1);
    send_word(OP_ALLOC, 32'h400, 32'h0);
    send_word(OP_FREE, 32'h400, 32'hFFFF_FFFF);
    send_word(OP_QUERY, 32'h400, 32'h0);
    send_word(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_slot_claims();
    send_word(OP_ALLOC, 32'h0000_0C01, 32'd100);
    send_word(OP_ALLOC, 32'h0000_0801, 32'd50);
    send_word(OP_QUERY, 32'h0000_0801, 32'd0);
    send_word(OP_QUERY, 32'h0000_0C01, 32'd0);
    send_word(OP_FREE, 32'h0000_0C01, 32'd100);
    send_word(OP_ALLOC, 32'h0000_0801, 32'd7);
    send_word(OP_QUERY, 32'h0000_0C01, 32'd0);
    send_word(OP_SPARE, 32'h0000_0801, 32'd0);
  endtask

  task automatic test_handle_zero();
    send_word(OP_FREE, 32'h400, 32'h1);
    send_word(OP_ALLOC, 32'h0, 32'h8000_0000);
    send_word(OP_FREE, 32'h0, 32'h7FFF_FFFF);
    send_word(OP_QUERY, 32'h0, 32'h0);
  endtask

  task automatic test_owner_pool(input int count);
    logic [HANDLE_W-1:0] pool [16];
    logic [9:0] base;
    logic [HANDLE_W-1:0] handle;
    logic [OP_W-1:0] op;
    logic [BYTES_W-1:0] nbytes;
    int pick;
    // crowd four slots with four owners each
    for (int s = 0; s < 4; s++) begin
      base = 10'($urandom_range(0, SLOTS - 1));
      for (int k = 0; k < 4; k++) pool[s * 4 + k] = {22'($urandom_range(0, 32'h3F_FFFF)), base};
    end
    pool[0][31:10] = '0;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) op = OP_ALLOC;
      else if (pick < 80) op = OP_FREE;
      else if (pick < 95) op = OP_QUERY;
      else op = OP_SPARE;
      handle = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, 15)];
      nbytes = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5000);
      send_word(op, handle, nbytes);
    end
  endtask

  task automatic test_random_noise(input int count);
    for (int i = 0; i < count; i++) begin
      send_word(OP_W'($urandom_range(0, 3)), $urandom, $urandom);
    end
  endtask

  task automatic test_pause_for_results();
    test_owner_pool(20);
    wait_for_results();
    test_owner_pool(20);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    sender_idles = 1'b1;
    stall_mode = STALL_RANDOM;
    test_empty_slots();
    test_counter_wrap();
    test_slot_claims();
    test_handle_zero();
    test_owner_pool(400);

    stall_mode = STALL_PERIODIC;
    test_random_noise(200);
    test_pause_for_results();

    sender_idles = 1'b0;
    stall_mode = STALL_NONE;
    test_owner_pool(150);

    sender_idles = 1'b1;
    stall_mode = STALL_RANDOM;
    test_owner_pool(60);

    wait_for_results();
    repeat (20) @(posedge clk);
    $display("Sent %0d events (allocations, frees, queries, spare code) over %0d cycles;",
             items_sent, cycle_count);
    $display("%0d results hit an owner slot, including wrapped totals and claimed slots.",
             owner_hits);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/poma_pkg.sv
hdl/poma_ram.sv
hdl/per_owner_memory_accounting.sv
tb/sv/tb_per_owner_memory_accounting.sv
